// ===== rtl/core/smpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smpl_pkg
// Shared types and constants of the stereo mixer with peak limiter: frame
// payloads, controller states, controller commands and fixed-point constants.
// ----------------------------------------------------------------------------
package smpl_pkg;

    localparam int SampleW = 16;
    localparam int MixW    = 19;
    localparam int PeakW   = 18;
    localparam int GainW   = 17;
    localparam int QuoW    = 16;
    localparam int ProdW   = MixW + GainW + 1;
    localparam int FracW   = 16;

    localparam int DivSteps = QuoW;
    localparam int CountW   = $clog2(DivSteps);

    localparam logic [PeakW-1:0] PEAK_LIMIT = PeakW'(32767);
    localparam logic [MixW-1:0]  REM_INIT   = MixW'(32767);
    localparam logic [GainW-1:0] GAIN_ONE   = GainW'(65536);

    typedef struct packed {
        logic signed [SampleW-1:0] fm_left;
        logic signed [SampleW-1:0] fm_right;
        logic signed [SampleW-1:0] tone_left;
        logic signed [SampleW-1:0] tone_right;
        logic signed [SampleW-1:0] wave_left;
        logic signed [SampleW-1:0] wave_right;
    } frame_in_t;

    typedef struct packed {
        logic signed [SampleW-1:0] out_left;
        logic signed [SampleW-1:0] out_right;
        logic [GainW-1:0]          gain_used;
    } frame_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAK,
        ST_DIV,
        ST_SEL,
        ST_MUL_L,
        ST_MUL_R,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic peak;
        logic div_step;
        logic sel_gain;
        logic mul_left;
        logic mul_right;
        logic finish;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/stereo_mixer_peak_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_mixer_peak_limiter
// Mixes three stereo sources (first at unit weight, the other two doubled)
// and scales both channels by a Q16 limiter gain that drops at once on peaks
// above full scale and recovers by one step per frame.
// ----------------------------------------------------------------------------
// One frame is processed at a time, from acceptance to the result register:
// the mix, peak detection, the restoring divider that computes the limit gain
// (one quotient bit per cycle), gain selection, the shared multiplier (left
// then right) and the write of the result. The next frame is accepted in the
// cycle after the write, while the previous result may still wait in the
// output register; a stalled output delays only the write of the following
// frame.
// ----------------------------------------------------------------------------
module stereo_mixer_peak_limiter
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire smpl_pkg::frame_in_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output smpl_pkg::frame_out_t      out_data
);
    import smpl_pkg::*;

    cmd_t cmd;

    smpl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    smpl_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/core/smpl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smpl_ctrl
// Frame sequencer: accepts one frame, steps the datapath through peak
// detection, the gain division, both channel products and the output write,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module smpl_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output smpl_pkg::cmd_t     cmd
);
    import smpl_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                cmd.peak   = 1'b1;
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == CountW'(DivSteps - 1))
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                cmd.sel_gain = 1'b1;
                state_next   = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_left = 1'b1;
                state_next   = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                cmd.mul_right = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/smpl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smpl_datapath
// Mix, peak, restoring divider for the limit gain, shared scaling multiplier,
// kept limiter gain and the output register.
// ----------------------------------------------------------------------------
module smpl_datapath
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire smpl_pkg::cmd_t       cmd,
    input  wire smpl_pkg::frame_in_t  in_data,
    output smpl_pkg::frame_out_t      out_data
);
    import smpl_pkg::*;

    logic signed [MixW-1:0]    mix_l_reg;
    logic signed [MixW-1:0]    mix_r_reg;
    logic signed [MixW-1:0]    mix_l_next;
    logic signed [MixW-1:0]    mix_r_next;
    logic [PeakW-1:0]          peak_reg;
    logic [PeakW-1:0]          peak_next;
    logic [MixW-1:0]           abs_l;
    logic [MixW-1:0]           abs_r;
    logic [MixW-1:0]           rem_reg;
    logic [MixW-1:0]           rem_next;
    logic [MixW-1:0]           rem_shift;
    logic [QuoW-1:0]           quo_reg;
    logic [QuoW-1:0]           quo_next;
    logic                      rem_ge;
    logic [GainW-1:0]          gain_reg;
    logic [GainW-1:0]          gain_next;
    logic [GainW-1:0]          gain_use_reg;
    logic [GainW-1:0]          gain_use_next;
    logic signed [MixW-1:0]    mul_a;
    logic signed [GainW:0]     mul_b;
    logic signed [ProdW-1:0]   prod_next;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [SampleW-1:0] left_res_reg;
    frame_out_t                out_reg;

    // fm + 2*tone + 2*wave per channel
    assign mix_l_next = {{3{in_data.fm_left[SampleW-1]}}, in_data.fm_left}
                      + {{2{in_data.tone_left[SampleW-1]}}, in_data.tone_left, 1'b0}
                      + {{2{in_data.wave_left[SampleW-1]}}, in_data.wave_left, 1'b0};
    assign mix_r_next = {{3{in_data.fm_right[SampleW-1]}}, in_data.fm_right}
                      + {{2{in_data.tone_right[SampleW-1]}}, in_data.tone_right, 1'b0}
                      + {{2{in_data.wave_right[SampleW-1]}}, in_data.wave_right, 1'b0};

    assign abs_l     = mix_l_reg[MixW-1] ? MixW'(-mix_l_reg) : MixW'(mix_l_reg);
    assign abs_r     = mix_r_reg[MixW-1] ? MixW'(-mix_r_reg) : MixW'(mix_r_reg);
    assign peak_next = (abs_l > abs_r) ? abs_l[PeakW-1:0] : abs_r[PeakW-1:0];

    // restoring division of 32767 << 16 by the peak, one quotient bit a step
    assign rem_shift = {rem_reg[MixW-2:0], 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, peak_reg};
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, peak_reg}) : rem_shift;
    assign quo_next  = {quo_reg[QuoW-2:0], rem_ge};

    assign gain_use_next = ((peak_reg > PEAK_LIMIT) && ({1'b0, quo_reg} < gain_reg))
                         ? {1'b0, quo_reg} : gain_reg;

    // one shared multiplier, left then right
    assign mul_a     = cmd.mul_left ? mix_l_reg : mix_r_reg;
    assign mul_b     = $signed({1'b0, gain_use_reg});
    assign prod_next = mul_a * mul_b;

    assign gain_next = (gain_use_reg < GAIN_ONE) ? (gain_use_reg + 1'b1) : gain_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_ONE;
        end
        else if (cmd.finish)
        begin
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mix_l_reg <= mix_l_next;
            mix_r_reg <= mix_r_next;
        end
        if (cmd.peak)
        begin
            peak_reg <= peak_next;
            rem_reg  <= REM_INIT;
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.sel_gain)
        begin
            gain_use_reg <= gain_use_next;
        end
        if (cmd.mul_left || cmd.mul_right)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_right)
        begin
            left_res_reg <= prod_reg[FracW+SampleW-1:FracW];
        end
        if (cmd.finish)
        begin
            out_reg.out_left  <= left_res_reg;
            out_reg.out_right <= prod_reg[FracW+SampleW-1:FracW];
            out_reg.gain_used <= gain_use_reg;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

// ===== tb/sv/stereo_mixer_peak_limiter_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_mixer_peak_limiter_test
// Self-checking bench for the stereo mixer with peak limiter. It drives
// directed and random frames through the valid/stall request channel and
// predicts each limited frame, including the gain drop and recovery, with a
// model of its own. It compares every result field by field and runs under
// several patterns of sender idling and receiver stalls, plus a long output
// hold-off.
// ----------------------------------------------------------------------------
module stereo_mixer_peak_limiter_test;
    import smpl_pkg::*;

    localparam int unsigned LIMIT_NUMERATOR = 32'd32767 << 16;
    localparam int          STALL_LIMIT     = 3000;
    localparam int          DRAIN_CYCLES    = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    frame_in_t  in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    frame_out_t out_data;

    logic [GainW-1:0] gain_q16 = GAIN_ONE;
    frame_out_t       limited_frames_due[$];
    int               mismatch_count = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_cycles    = 0;
    int               quiet_cycles   = 0;

    stereo_mixer_peak_limiter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mix, limit and scale one frame; advances the kept gain
    function automatic frame_out_t limit_frame(frame_in_t f);
        int               mix_l;
        int               mix_r;
        int unsigned      mag_l;
        int unsigned      mag_r;
        int unsigned      peak;
        int unsigned      cand;
        logic [GainW-1:0] gain;
        longint           prod_l;
        longint           prod_r;
        frame_out_t       r;
        mix_l = int'(f.fm_left) + 2 * int'(f.tone_left) + 2 * int'(f.wave_left);
        mix_r = int'(f.fm_right) + 2 * int'(f.tone_right) + 2 * int'(f.wave_right);
        mag_l = (mix_l < 0) ? -mix_l : mix_l;
        mag_r = (mix_r < 0) ? -mix_r : mix_r;
        peak  = (mag_l > mag_r) ? mag_l : mag_r;
        gain  = gain_q16;
        if (peak > PEAK_LIMIT)
        begin
            cand = LIMIT_NUMERATOR / peak;
            if (cand < gain)
                gain = GainW'(cand);
        end
        prod_l      = longint'(mix_l) * longint'(gain);
        prod_r      = longint'(mix_r) * longint'(gain);
        r.out_left  = SampleW'(prod_l >>> FracW);
        r.out_right = SampleW'(prod_r >>> FracW);
        r.gain_used = gain;
        gain_q16    = (gain < GAIN_ONE) ? gain + 1'b1 : gain;
        return r;
    endfunction

    function automatic frame_in_t make_frame(int fl, int fr, int tl, int tr, int wl, int wr);
        frame_in_t f;
        f.fm_left    = SampleW'(fl);
        f.fm_right   = SampleW'(fr);
        f.tone_left  = SampleW'(tl);
        f.tone_right = SampleW'(tr);
        f.wave_left  = SampleW'(wl);
        f.wave_right = SampleW'(wr);
        return f;
    endfunction

    function automatic logic [SampleW-1:0] pick_sample(int profile);
        int pick;
        case (profile)
            0: return SampleW'($urandom_range(12000) - 6000);
            1: return SampleW'($urandom);
            2:
            begin
                pick = $urandom_range(5);
                case (pick)
                    0: return SampleW'(-32768);
                    1: return SampleW'(32767);
                    2: return SampleW'(-32767);
                    3: return SampleW'(-1);
                    4: return SampleW'(1);
                    default: return '0;
                endcase
            end
            default: return SampleW'($urandom_range(32767, 16384));
        endcase
    endfunction

    function automatic frame_in_t random_frame();
        int        r;
        int        profile;
        frame_in_t f;
        r = $urandom_range(99);
        profile = (r < 35) ? 0 : (r < 60) ? 1 : (r < 80) ? 2 : 3;
        f.fm_left    = pick_sample(profile);
        f.fm_right   = pick_sample(profile);
        f.tone_left  = pick_sample(profile);
        f.tone_right = pick_sample(profile);
        f.wave_left  = pick_sample(profile);
        f.wave_right = pick_sample(profile);
        // loud frames push one channel of each source the same way
        if (profile == 3 && $urandom_range(1))
        begin
            f.fm_right   = -f.fm_right;
            f.tone_right = -f.tone_right;
            f.wave_right = -f.wave_right;
        end
        return f;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_frame(input frame_in_t f);
        in_valid <= 1'b1;
        in_data  <= f;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        limited_frames_due.push_back(limit_frame(f));
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (limited_frames_due.size() != 0);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (limited_frames_due.size() == 0)
                report_mismatch("unexpected frame", int'(out_data.out_left), 0);
            else
            begin
                frame_out_t want;
                want = limited_frames_due.pop_front();
                if (out_data.out_left !== want.out_left)
                    report_mismatch("out_left", int'(out_data.out_left), int'(want.out_left));
                if (out_data.out_right !== want.out_right)
                    report_mismatch("out_right", int'(out_data.out_right),
                                    int'(want.out_right));
                if (out_data.gain_used !== want.gain_used)
                    report_mismatch("gain_used", int'(out_data.gain_used),
                                    int'(want.gain_used));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(32767, 0, 0, 0, 0, 0));
        // full-scale negative is just over the limit
        send_frame(make_frame(0, -32768, 0, 0, 0, 0));
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(-1, 1, 0, 0, 0, 0));
        send_frame(make_frame(0, 0, 16384, 0, 0, 0));
        send_frame(make_frame(0, 1, 0, 0, 0, 16383));
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1, -1, 0, 0, 0, 0));
        send_frame(make_frame(32767, -32768, -16384, 16384, -8192, 8191));
        send_frame(make_frame(32767, 0, 32767, 0, 32767, 0));
        // deepest drop reaches the gain floor
        send_frame(make_frame(0, -32768, 0, -32768, 0, -32768));
        send_frame(make_frame(32767, 32767, 32767, 32767, 32767, 32767));
        send_frame(make_frame(-32768, -32768, -32768, -32768, -32768, -32768));
        send_frame(make_frame(32767, -32768, 32767, -32768, 32767, -32768));
        send_frame(make_frame(-32768, 32767, -32768, 32767, -32768, 32767));
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(5, -5, 100, -100, -7, 7));
        wait_all_results();
    endtask

    task automatic test_random_frames(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_frame(random_frame());
    endtask

    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_cycles = 300;
        @(negedge clk);
        repeat (12)
            send_frame(random_frame());
        wait_all_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_frames(400, 0, 0);
        test_random_frames(400, 76, 0);
        wait_all_results();
        test_output_hold();
        test_random_frames(400, 0, 76);
        test_random_frames(420, 17, 17);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/smpl_pkg.sv
rtl/core/smpl_ctrl.sv
rtl/core/smpl_datapath.sv
rtl/core/stereo_mixer_peak_limiter.sv
tb/sv/stereo_mixer_peak_limiter_test.sv
